>>> hw/rtl/fm0_pkg.sv
// Shared types, constants and control-word layout for the FM0 frame line encoder.
// No dependencies; imported by every module of the block.
package fm0_pkg;

    localparam int MAX_PREAMBLE_DEF = 6;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP       = 2'd3;

    localparam logic [7:0]  PATTERN_RST   = 8'd170;
    localparam logic [2:0]  PRE_BYTES_RST = 3'd2;
    localparam logic [15:0] PERIOD_RST    = 16'd1600;
    localparam logic [15:0] GAP_RST       = 16'd16000;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef logic [2:0] step_t;

    localparam step_t STEP_FETCH     = 3'd0;
    localparam step_t STEP_PRE_INIT  = 3'd1;
    localparam step_t STEP_PRE_CHK   = 3'd2;
    localparam step_t STEP_PRE_BIT   = 3'd3;
    localparam step_t STEP_LOAD_DATA = 3'd4;
    localparam step_t STEP_DATA_BIT  = 3'd5;
    localparam step_t STEP_END_CHK   = 3'd6;
    localparam step_t STEP_GAP       = 3'd7;

    typedef enum logic [2:0] {
        OP_FETCH,
        OP_PRE_INIT,
        OP_PRE_LOAD,
        OP_EMIT_PRE,
        OP_LOAD_DATA,
        OP_EMIT_DATA,
        OP_NOP,
        OP_EMIT_GAP
    } ctl_op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_START,
        COND_PRE_ZERO,
        COND_BIT_MORE,
        COND_FRAME_END
    } cond_t;

    typedef struct packed {
        ctl_op_t op;
        cond_t   cond;
        step_t   tgt_true;
        step_t   tgt_false;
    } ctl_word_t;

    typedef struct packed {
        logic [7:0]  pattern;
        logic [2:0]  pre_bytes;
        logic [15:0] period;
        logic [15:0] gap;
    } cfg_t;

    typedef struct packed {
        logic pre_zero;
        logic bit_more;
        logic frame_end;
        logic out_busy;
    } dp_status_t;

endpackage

>>> hw/rtl/fm0_ucode_rom.sv
// Control store of the FM0 sequencer: one control word per step.
// Depends on fm0_pkg for the control-word layout and step codes.
module fm0_ucode_rom
    import fm0_pkg::*;
(
    input  step_t     step,
    output ctl_word_t word
);

    always_comb
    begin
        unique case (step)
            STEP_FETCH:     word = '{OP_FETCH,     COND_IN_START,  STEP_PRE_INIT, STEP_LOAD_DATA};
            STEP_PRE_INIT:  word = '{OP_PRE_INIT,  COND_ALWAYS,    STEP_PRE_CHK,  STEP_PRE_CHK};
            STEP_PRE_CHK:   word = '{OP_PRE_LOAD,  COND_PRE_ZERO,  STEP_LOAD_DATA, STEP_PRE_BIT};
            STEP_PRE_BIT:   word = '{OP_EMIT_PRE,  COND_BIT_MORE,  STEP_PRE_BIT,  STEP_PRE_CHK};
            STEP_LOAD_DATA: word = '{OP_LOAD_DATA, COND_ALWAYS,    STEP_DATA_BIT, STEP_DATA_BIT};
            STEP_DATA_BIT:  word = '{OP_EMIT_DATA, COND_BIT_MORE,  STEP_DATA_BIT, STEP_END_CHK};
            STEP_END_CHK:   word = '{OP_NOP,       COND_FRAME_END, STEP_GAP,      STEP_FETCH};
            STEP_GAP:       word = '{OP_EMIT_GAP,  COND_ALWAYS,    STEP_FETCH,    STEP_FETCH};
            default:        word = '{OP_NOP,       COND_ALWAYS,    STEP_FETCH,    STEP_FETCH};
        endcase
    end

endmodule

>>> hw/rtl/fm0_datapath.sv
// Datapath of the FM0 encoder: shift register, bit and preamble counters, line level
// and the result register. Driven by control words; depends on fm0_pkg.
module fm0_datapath
    import fm0_pkg::*;
#(
    parameter int MAX_PREAMBLE = MAX_PREAMBLE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_op_t     op,
    input  logic        go,
    input  cfg_t        cfg,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    input  logic        out_ready,
    output dp_status_t  status,
    output logic        out_valid,
    output logic        first_half_level,
    output logic        second_half_level,
    output logic [15:0] hold_ticks,
    output logic        gap_symbol,
    output logic        last_of_run
);

    localparam int PW = (MAX_PREAMBLE > 0) ? $clog2(MAX_PREAMBLE + 1) : 1;

    logic [7:0]    data_reg, data_next;
    logic [7:0]    shift_reg, shift_next;
    logic [2:0]    bit_cnt_reg, bit_cnt_next;
    logic [PW-1:0] pre_cnt_reg, pre_cnt_next;
    logic          end_reg, end_next;
    logic          line_reg, line_next;
    logic          out_valid_reg, out_valid_next;
    logic          first_reg, first_next;
    logic          second_reg, second_next;
    logic [15:0]   hold_reg, hold_next;
    logic          gap_reg, gap_next;
    logic          last_reg, last_next;
    logic          bit_level;

    assign bit_level = ~line_reg;

    always_comb
    begin
        data_next      = data_reg;
        shift_next     = shift_reg;
        bit_cnt_next   = bit_cnt_reg;
        pre_cnt_next   = pre_cnt_reg;
        end_next       = end_reg;
        line_next      = line_reg;
        out_valid_next = out_valid_reg && !out_ready;
        first_next     = first_reg;
        second_next    = second_reg;
        hold_next      = hold_reg;
        gap_next       = gap_reg;
        last_next      = last_reg;
        if (go)
        begin
            unique case (op)
                OP_FETCH:
                begin
                    data_next = data_byte;
                    end_next  = frame_end;
                end
                OP_PRE_INIT:
                begin
                    line_next = 1'b0;
                    if (int'(cfg.pre_bytes) > MAX_PREAMBLE)
                        pre_cnt_next = PW'(MAX_PREAMBLE);
                    else
                        pre_cnt_next = PW'(cfg.pre_bytes);
                end
                OP_PRE_LOAD:
                begin
                    shift_next   = cfg.pattern;
                    bit_cnt_next = LAST_BIT;
                    if (pre_cnt_reg != '0)
                        pre_cnt_next = pre_cnt_reg - PW'(1);
                end
                OP_LOAD_DATA:
                begin
                    shift_next   = data_reg;
                    bit_cnt_next = LAST_BIT;
                end
                OP_EMIT_PRE, OP_EMIT_DATA:
                begin
                    shift_next     = {shift_reg[6:0], 1'b0};
                    bit_cnt_next   = bit_cnt_reg - 3'd1;
                    line_next      = shift_reg[7] ? bit_level : line_reg;
                    out_valid_next = 1'b1;
                    first_next     = bit_level;
                    second_next    = shift_reg[7] ? bit_level : line_reg;
                    hold_next      = {1'b0, cfg.period[15:1]};
                    gap_next       = 1'b0;
                    last_next      = (op == OP_EMIT_DATA) && (bit_cnt_reg == '0) && !end_reg;
                end
                OP_EMIT_GAP:
                begin
                    line_next      = bit_level;
                    out_valid_next = 1'b1;
                    first_next     = bit_level;
                    second_next    = bit_level;
                    hold_next      = cfg.gap;
                    gap_next       = 1'b1;
                    last_next      = 1'b1;
                end
                OP_NOP:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg   <= '0;
            pre_cnt_reg   <= '0;
            line_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bit_cnt_reg   <= bit_cnt_next;
            pre_cnt_reg   <= pre_cnt_next;
            line_reg      <= line_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        shift_reg  <= shift_next;
        end_reg    <= end_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        hold_reg   <= hold_next;
        gap_reg    <= gap_next;
        last_reg   <= last_next;
    end

    assign status.pre_zero  = (pre_cnt_reg == '0);
    assign status.bit_more  = (bit_cnt_reg != '0);
    assign status.frame_end = end_reg;
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign out_valid         = out_valid_reg;
    assign first_half_level  = first_reg;
    assign second_half_level = second_reg;
    assign hold_ticks        = hold_reg;
    assign gap_symbol        = gap_reg;
    assign last_of_run       = last_reg;

endmodule

>>> hw/rtl/fm0_frame_line_encoder.sv
// Top level of the FM0 frame line encoder: step counter, jump logic, configuration
// registers. Depends on fm0_pkg, fm0_ucode_rom and fm0_datapath.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------------------
//   in      | input     | in_valid / in_ready   | data_byte, frame_start, frame_end
//   out     | output    | out_valid / out_ready | first/second_half_level, hold_ticks,
//           |           |                       | gap_symbol, last_of_run
//   cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// One control step per cycle unless a fetch waits for input or a held result stalls an
// emitting step. Preamble bytes precede a byte that opens a frame and the gap symbol
// follows one that closes it; each preamble or data bit is one step emitting one symbol.
// Reset puts the step counter at fetch and the configuration registers at their defaults.
// A result left untaken freezes the step counter at the next emitting step.
module fm0_frame_line_encoder
    import fm0_pkg::*;
#(
    parameter int MAX_PREAMBLE = MAX_PREAMBLE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  frame_start,
    input  logic                  frame_end,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  first_half_level,
    output logic                  second_half_level,
    output logic [15:0]           hold_ticks,
    output logic                  gap_symbol,
    output logic                  last_of_run,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    step_t      step_reg, step_next;
    ctl_word_t  word;
    dp_status_t status;
    cfg_t       cfg_reg, cfg_next;
    logic       go;
    logic       emit;
    logic       taken;

    fm0_ucode_rom u_rom
    (
        .step (step_reg),
        .word (word)
    );

    fm0_datapath #(
        .MAX_PREAMBLE (MAX_PREAMBLE)
    ) u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .op                (word.op),
        .go                (go),
        .cfg               (cfg_reg),
        .data_byte         (data_byte),
        .frame_end         (frame_end),
        .out_ready         (out_ready),
        .status            (status),
        .out_valid         (out_valid),
        .first_half_level  (first_half_level),
        .second_half_level (second_half_level),
        .hold_ticks        (hold_ticks),
        .gap_symbol        (gap_symbol),
        .last_of_run       (last_of_run)
    );

    assign emit     = (word.op == OP_EMIT_PRE) || (word.op == OP_EMIT_DATA)
                      || (word.op == OP_EMIT_GAP);
    assign in_ready = (word.op == OP_FETCH);
    assign go       = (in_ready && in_valid) || (emit && !status.out_busy)
                      || (!in_ready && !emit);

    always_comb
    begin
        unique case (word.cond)
            COND_ALWAYS:    taken = 1'b1;
            COND_IN_START:  taken = frame_start;
            COND_PRE_ZERO:  taken = status.pre_zero;
            COND_BIT_MORE:  taken = status.bit_more;
            COND_FRAME_END: taken = status.frame_end;
            default:        taken = 1'b1;
        endcase
        step_next = step_reg;
        if (go)
            step_next = taken ? word.tgt_true : word.tgt_false;
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PATTERN:   cfg_next.pattern   = cfg_data[7:0];
                CFG_PRE_BYTES: cfg_next.pre_bytes = cfg_data[2:0];
                CFG_PERIOD:    cfg_next.period    = cfg_data[15:0];
                CFG_GAP:       cfg_next.gap       = cfg_data[15:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_FETCH;
            cfg_reg  <= '{PATTERN_RST, PRE_BYTES_RST, PERIOD_RST, GAP_RST};
        end
        else
        begin
            step_reg <= step_next;
            cfg_reg  <= cfg_next;
        end
    end

    // an unmarked item goes straight to loading its data
    a_no_start_skips_preamble: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !frame_start |=> step_reg == STEP_LOAD_DATA)
        else $error("item without frame start did not skip the preamble");

    // preamble symbols never close an item
    a_pre_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        go && word.op == OP_EMIT_PRE |=> out_valid && !last_of_run && !gap_symbol)
        else $error("preamble symbol marked as last of run");

    // the final data bit of an unclosed frame byte closes the item and moves to the end check
    a_last_data_bit: assert property (@(posedge clk) disable iff (!rst_n)
        go && word.op == OP_EMIT_DATA && !status.bit_more && !status.frame_end
        |=> out_valid && last_of_run && step_reg == STEP_END_CHK)
        else $error("final data bit did not close the item");

    // a gap symbol is always the last of its run
    a_gap_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gap_symbol |-> last_of_run)
        else $error("gap symbol not marked as last of run");

    // the step counter holds at an emitting step while a result waits
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        emit && status.out_busy |=> $stable(step_reg))
        else $error("sequencer advanced over a stalled result");

endmodule
